// ===== src/ssba_pkg.sv =====
package ssba_pkg;

    // Field widths of the ports
    localparam int SLOT_W = 10;
    localparam int ADDR_W = 13;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 11;

    // Bitmap word organization
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;

    // Parameter defaults
    localparam int NUM_SLOTS_DEF        = 1024;
    localparam int SECTORS_PER_SLOT_DEF = 8;

    // Reset value of the slot count register
    localparam logic [CFG_W-1:0] SLOT_COUNT_RST = 11'd1024;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOT_OCC = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_CHK,
        S_IN_EV,
        S_EMIT,
        S_RESP
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic    clr_wr;
        logic    take_req;
        logic    scan_rd;
        logic    scan_next;
        logic    scan_take;
        logic    chk_rd;
        logic    free_wr;
        logic    out_sector;
        logic    out_err;
        t_status err_code;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_done;
        logic scan_end;
        logic word_full;
        logic cand_ok;
        logic range_bad;
        logic bit_set;
        logic out_free;
        logic idx_last;
        logic req_type;
    } t_dp_sts;

endpackage

// ===== src/ssba_ram.sv =====
module ssba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ssba_ctrl.sv =====
module ssba_ctrl
    import ssba_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_in_stall
);

    t_state  r_state, n_state;
    t_status r_err, n_err;

    // State and error code registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_err   <= ST_OK;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_err   = r_err;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = i_sts.req_type ? S_CHK : S_SCAN_RD;
            end
            S_SCAN_RD: begin
                if (i_sts.scan_end) begin
                    n_err   = ST_FULL;
                    n_state = S_RESP;
                end else begin
                    n_state = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                priority if (i_sts.word_full) begin
                    n_state = S_SCAN_RD;
                end else if (i_sts.cand_ok) begin
                    n_state = S_EMIT;
                end else begin
                    n_err   = ST_FULL;
                    n_state = S_RESP;
                end
            end
            S_CHK: begin
                if (i_sts.range_bad) begin
                    n_err   = ST_RANGE;
                    n_state = S_RESP;
                end else begin
                    n_state = S_IN_EV;
                end
            end
            S_IN_EV: begin
                if (!i_sts.bit_set) begin
                    n_err   = ST_NOT_OCC;
                    n_state = S_RESP;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free && i_sts.idx_last) n_state = S_IDLE;
            end
            S_RESP: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.err_code = r_err;
        o_in_stall     = 1'b1;
        unique case (r_state)
            S_CLEAR:   o_cmd.clr_wr = 1'b1;
            S_IDLE: begin
                o_in_stall     = 1'b0;
                o_cmd.take_req = i_in_valid;
            end
            S_SCAN_RD: o_cmd.scan_rd = !i_sts.scan_end;
            S_SCAN_EV: begin
                o_cmd.scan_next = i_sts.word_full;
                o_cmd.scan_take = !i_sts.word_full && i_sts.cand_ok;
            end
            S_CHK:     o_cmd.chk_rd = !i_sts.range_bad;
            S_IN_EV:   o_cmd.free_wr = i_sts.bit_set;
            S_EMIT:    o_cmd.out_sector = i_sts.out_free;
            S_RESP:    o_cmd.out_err = i_sts.out_free;
            default:   o_cmd = '0;
        endcase
    end

endmodule

// ===== src/ssba_dp.sv =====
module ssba_dp
    import ssba_pkg::*;
#(
    parameter int NUM_SLOTS        = NUM_SLOTS_DEF,
    parameter int SECTORS_PER_SLOT = SECTORS_PER_SLOT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_req_type,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic              i_out_stall,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    output logic              o_out_valid,
    output logic [ADDR_W-1:0] o_sector_addr,
    output logic [IDX_W-1:0]  o_sector_index,
    output logic              o_is_write,
    output logic [SLOT_W-1:0] o_slot_used,
    output logic [1:0]        o_status,
    output logic              o_last
);

    localparam int NUM_WORDS = (NUM_SLOTS + WORD_W - 1) / WORD_W;
    localparam int WA    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int WCW   = $clog2(NUM_WORDS + 1);
    localparam int SLW   = ((WA + BIT_W) > SLOT_W) ? (WA + BIT_W) : SLOT_W;
    localparam int CNW0  = $clog2(NUM_SLOTS + 1);
    localparam int CNT_W = (CNW0 > CFG_W) ? CNW0 : CFG_W;
    localparam int CMW0  = (SLW > CNT_W) ? SLW : CNT_W;
    localparam int CMP_W = (((WCW + BIT_W) > CMW0) ? (WCW + BIT_W) : CMW0) + 1;
    localparam int IW    = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;
    localparam int PW    = SLW + IW;

    logic [CFG_W-1:0]  r_slot_count;
    logic [SLW-1:0]    r_slot;
    logic [WCW-1:0]    r_wcnt;
    logic [IW-1:0]     r_idx;
    logic              r_is_wr;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_addr;
    logic [IDX_W-1:0]  r_oidx;
    logic              r_owr;
    logic [SLOT_W-1:0] r_oslot;
    t_status           r_status;
    logic              r_last;

    logic [CNT_W-1:0]  usable;
    logic [CMP_W-1:0]  base;
    logic [CMP_W-1:0]  cand;
    logic [BIT_W-1:0]  zero_pos;
    logic              zero_found;
    logic [WORD_W-1:0] rd_data;
    logic              ram_we;
    logic [WA-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [WA-1:0]     ram_raddr;
    logic [WA-1:0]     slot_word;
    logic [PW-1:0]     addr_full;
    logic              out_free;

    // Slot count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= SLOT_COUNT_RST;
        end else if (i_cfg_we) begin
            r_slot_count <= i_cfg_data;
        end
    end

    // Usable count: register value clipped to the bitmap size
    assign usable = (CNT_W'(r_slot_count) > CNT_W'(NUM_SLOTS)) ?
                    CNT_W'(NUM_SLOTS) : CNT_W'(r_slot_count);

    // Lowest free bit of the word just read
    always_comb begin
        zero_pos   = '0;
        zero_found = 1'b0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!rd_data[i]) begin
                zero_pos   = BIT_W'(i);
                zero_found = 1'b1;
            end
        end
    end

    assign base      = CMP_W'({r_wcnt, {BIT_W{1'b0}}});
    assign cand      = CMP_W'({r_wcnt, zero_pos});
    assign slot_word = r_slot[BIT_W +: WA];
    assign out_free  = !r_out_valid || !i_out_stall;

    // Bitmap memory access
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wcnt[WA-1:0];
        ram_wdata = '0;
        priority if (i_cmd.clr_wr) begin
            ram_we = 1'b1;
        end else if (i_cmd.scan_take) begin
            ram_we    = 1'b1;
            ram_wdata = rd_data | (WORD_W'(1) << zero_pos);
        end else if (i_cmd.free_wr) begin
            ram_we    = 1'b1;
            ram_waddr = slot_word;
            ram_wdata = rd_data & ~(WORD_W'(1) << r_slot[BIT_W-1:0]);
        end else begin
            ram_we = 1'b0;
        end
        ram_re    = i_cmd.scan_rd || i_cmd.chk_rd;
        ram_raddr = i_cmd.chk_rd ? slot_word : r_wcnt[WA-1:0];
    end

    ssba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    // Word counter: clearing pass, then free-slot scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt <= '0;
        end else if (i_cmd.take_req) begin
            r_wcnt <= '0;
        end else if (i_cmd.clr_wr || i_cmd.scan_next) begin
            r_wcnt <= r_wcnt + WCW'(1);
        end
    end

    // Request slot, direction and sector counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_slot  <= SLW'(i_slot);
            r_is_wr <= !i_req_type;
            r_idx   <= '0;
        end else begin
            if (i_cmd.scan_take) r_slot <= SLW'(cand);
            if (i_cmd.out_sector) r_idx <= r_idx + IW'(1);
        end
    end

    // Sector address of the current command
    assign addr_full = PW'(r_slot) * PW'(SECTORS_PER_SLOT) + PW'(r_idx);

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_sector || i_cmd.out_err) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_sector) begin
            r_addr   <= ADDR_W'(addr_full);
            r_oidx   <= IDX_W'(r_idx);
            r_owr    <= r_is_wr;
            r_oslot  <= SLOT_W'(r_slot);
            r_status <= ST_OK;
            r_last   <= (r_idx == IW'(SECTORS_PER_SLOT - 1));
        end else if (i_cmd.out_err) begin
            r_addr   <= '0;
            r_oidx   <= '0;
            r_owr    <= (i_cmd.err_code == ST_FULL);
            r_oslot  <= (i_cmd.err_code == ST_FULL) ? '0 : SLOT_W'(r_slot);
            r_status <= i_cmd.err_code;
            r_last   <= 1'b1;
        end
    end

    // Status to the controller
    always_comb begin
        o_sts.clr_done  = (r_wcnt == WCW'(NUM_WORDS - 1));
        o_sts.scan_end  = (base >= CMP_W'(usable));
        o_sts.word_full = !zero_found;
        o_sts.cand_ok   = (cand < CMP_W'(usable));
        o_sts.range_bad = (CMP_W'(r_slot) >= CMP_W'(usable));
        o_sts.bit_set   = rd_data[r_slot[BIT_W-1:0]];
        o_sts.out_free  = out_free;
        o_sts.idx_last  = (r_idx == IW'(SECTORS_PER_SLOT - 1));
        o_sts.req_type  = i_req_type;
    end

    assign o_out_valid    = r_out_valid;
    assign o_sector_addr  = r_addr;
    assign o_sector_index = r_oidx;
    assign o_is_write     = r_owr;
    assign o_slot_used    = r_oslot;
    assign o_status       = r_status;
    assign o_last         = r_last;

endmodule

// ===== src/swap_slot_bitmap_allocator_unit.sv =====
// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_stall    i_req_type, i_slot
// result    out        o_out_valid / i_out_stall  o_sector_addr, o_sector_index,
//                                                 o_is_write, o_slot_used,
//                                                 o_status, o_last
// config    in         i_cfg_we                   i_cfg_data (slot count)
//
// Swap out: each 32-slot bitmap word scanned takes one RAM read and one
// evaluate, then the sector commands follow. Swap in: a range check with the
// bit read, then an evaluate, then the sector commands. An error gives
// one result after the check.
// After reset a clearing pass writes one bitmap word a cycle,
// all ceil(NUM_SLOTS/32) words (32 by default), before the first request is taken.
// One request at a time; the next is taken while the last result still waits
// in the output register. Output stalls hold the sector sequence in place.
module swap_slot_bitmap_allocator_unit
    import ssba_pkg::*;
#(
    parameter int NUM_SLOTS        = NUM_SLOTS_DEF,
    parameter int SECTORS_PER_SLOT = SECTORS_PER_SLOT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_req_type,
    input  logic [SLOT_W-1:0] i_slot,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [ADDR_W-1:0] o_sector_addr,
    output logic [IDX_W-1:0]  o_sector_index,
    output logic              o_is_write,
    output logic [SLOT_W-1:0] o_slot_used,
    output logic [1:0]        o_status,
    output logic              o_last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer
    ssba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Bitmap, scan logic and output register
    ssba_dp #(
        .NUM_SLOTS        (NUM_SLOTS),
        .SECTORS_PER_SLOT (SECTORS_PER_SLOT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (i_req_type),
        .i_slot         (i_slot),
        .i_out_stall    (i_out_stall),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .o_sector_addr  (o_sector_addr),
        .o_sector_index (o_sector_index),
        .o_is_write     (o_is_write),
        .o_slot_used    (o_slot_used),
        .o_status       (o_status),
        .o_last         (o_last)
    );

endmodule

// ===== dv/tb.sv =====
import ssba_pkg::*;

// Request codes on i_req_type
localparam logic REQ_SWAP_OUT = 1'b0;
localparam logic REQ_SWAP_IN  = 1'b1;

// One sector command or error status, as seen on the result channel
typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [IDX_W-1:0]  index;
    logic              is_write;
    logic [SLOT_W-1:0] slot;
    t_status           status;
    logic              last;
} t_sector_cmd;

// Tracks slot occupancy and holds the sector commands still owed by the block
class slot_alloc_scoreboard;
    bit               slot_busy[NUM_SLOTS_DEF];
    logic [CFG_W-1:0] slot_count;
    t_sector_cmd      pending_cmds[$];
    int               mismatches;
    int               requests;
    int               results;
    int               status_seen[4];
    int               deepest_slot;

    function new();
        slot_count = SLOT_COUNT_RST;
        foreach (slot_busy[s]) slot_busy[s] = 1'b0;
        mismatches   = 0;
        requests     = 0;
        results      = 0;
        deepest_slot = -1;
        foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    function void set_slot_count(logic [CFG_W-1:0] value);
        slot_count = value;
    endfunction

    // Register values above the slot array size act as the full array
    function int usable_slots();
        return (slot_count > NUM_SLOTS_DEF) ? NUM_SLOTS_DEF : int'(slot_count);
    endfunction

    function void push_cmd(int addr, int index, logic wr, int slot, t_status st,
                           logic last);
        t_sector_cmd c;
        c.addr     = ADDR_W'(addr);
        c.index    = IDX_W'(index);
        c.is_write = wr;
        c.slot     = SLOT_W'(slot);
        c.status   = st;
        c.last     = last;
        pending_cmds.push_back(c);
        status_seen[int'(st)]++;
    endfunction

    function void push_sectors(int slot, logic wr);
        for (int i = 0; i < SECTORS_PER_SLOT_DEF; i++)
            push_cmd(slot * SECTORS_PER_SLOT_DEF + i, i, wr, slot, ST_OK,
                     i == SECTORS_PER_SLOT_DEF - 1);
    endfunction

    // Predict the commands for one accepted request and update occupancy
    function void note_request(logic req, logic [SLOT_W-1:0] slot);
        int lim;
        int s;
        lim = usable_slots();
        requests++;
        if (req == REQ_SWAP_OUT) begin
            s = 0;
            while (s < lim && slot_busy[s]) s++;
            if (s >= lim) begin
                push_cmd(0, 0, 1'b1, 0, ST_FULL, 1'b1);
            end else begin
                slot_busy[s] = 1'b1;
                if (s > deepest_slot) deepest_slot = s;
                push_sectors(s, 1'b1);
            end
        end else if (int'(slot) >= lim) begin
            push_cmd(0, 0, 1'b0, int'(slot), ST_RANGE, 1'b1);
        end else if (!slot_busy[slot]) begin
            push_cmd(0, 0, 1'b0, int'(slot), ST_NOT_OCC, 1'b1);
        end else begin
            slot_busy[slot] = 1'b0;
            push_sectors(int'(slot), 1'b0);
        end
    endfunction

    // Compare one accepted result with the oldest outstanding command
    function void check_result(t_sector_cmd got);
        t_sector_cmd want;
        results++;
        if (pending_cmds.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"ERROR: unexpected result addr=%0d idx=%0d wr=%0b",
                          " slot=%0d st=%0d last=%0b"},
                         got.addr, got.index, got.is_write, got.slot, got.status, got.last);
            return;
        end
        want = pending_cmds.pop_front();
        if (got.addr !== want.addr || got.index !== want.index
                || got.is_write !== want.is_write || got.slot !== want.slot
                || got.status !== want.status || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display({"ERROR: result %0d expected addr=%0d idx=%0d wr=%0b",
                          " slot=%0d st=%0d last=%0b"},
                         results, want.addr, want.index, want.is_write, want.slot,
                         want.status, want.last);
                $display({"       got                addr=%0d idx=%0d wr=%0b",
                          " slot=%0d st=%0d last=%0b"},
                         got.addr, got.index, got.is_write, got.slot, got.status, got.last);
            end
        end
    endfunction

    // Anything still owed at the end is a failure
    function void check_drained();
        if (pending_cmds.size() != 0) begin
            mismatches += pending_cmds.size();
            $display("ERROR: %0d results never arrived", pending_cmds.size());
        end
    endfunction

    // Random occupied slot inside the usable range, -1 when there is none
    function int pick_busy_slot();
        int busy_q[$];
        int lim;
        lim = usable_slots();
        for (int s = 0; s < lim; s++)
            if (slot_busy[s]) busy_q.push_back(s);
        if (busy_q.size() == 0) return -1;
        return busy_q[$urandom_range(0, busy_q.size() - 1)];
    endfunction
endclass

module tb;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              req_type = 1'b0;
    logic [SLOT_W-1:0] slot = '0;
    logic              out_stall = 1'b0;

    logic              in_stall;
    logic              out_valid;
    logic [ADDR_W-1:0] sector_addr;
    logic [IDX_W-1:0]  sector_index;
    logic              is_write;
    logic [SLOT_W-1:0] slot_used;
    logic [1:0]        status;
    logic              last;

    slot_alloc_scoreboard alloc_sb;
    bit                   burst_mode = 1'b0;
    int                   settings_used = 0;

    swap_slot_bitmap_allocator_unit u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_req_type     (req_type),
        .i_slot         (slot),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_sector_addr  (sector_addr),
        .o_sector_index (sector_index),
        .o_is_write     (is_write),
        .o_slot_used    (slot_used),
        .o_status       (status),
        .o_last         (last)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit
    initial begin
        #2000000;
        $display("swap_slot_bitmap_allocator_unit: mismatch");
        $finish;
    end

    // Idle cycles before the next item; none during bursts
    function automatic int draw_wait();
        return burst_mode ? 0 : $urandom_range(0, 6);
    endfunction

    // Present one request and hold it until the block takes it
    task automatic issue_request(input logic req, input logic [SLOT_W-1:0] s);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        slot     <= s;
        do @(posedge clk); while (in_stall !== 1'b0);
        alloc_sb.note_request(req, s);
    endtask

    // Stop sending and let every outstanding command come out
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (alloc_sb.pending_cmds.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_slot_count(input logic [CFG_W-1:0] value);
        wait_for_results();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        alloc_sb.set_slot_count(value);
        settings_used++;
    endtask

    // Swap-ins mostly target occupied slots so frees actually happen
    task automatic random_request(input int alloc_pct);
        logic [SLOT_W-1:0] s;
        int busy;
        int lim;
        int r;
        s = SLOT_W'($urandom_range(0, NUM_SLOTS_DEF - 1));
        if ($urandom_range(0, 99) < alloc_pct) begin
            issue_request(REQ_SWAP_OUT, s);
        end else begin
            busy = alloc_sb.pick_busy_slot();
            lim  = alloc_sb.usable_slots();
            r    = $urandom_range(0, 99);
            if (r < 70 && busy >= 0)
                s = SLOT_W'(busy);
            else if (r < 85 && lim > 0)
                s = SLOT_W'($urandom_range(0, lim - 1));
            issue_request(REQ_SWAP_IN, s);
        end
    endtask

    // Result side: random stalls, check every accepted item
    initial begin : result_sink
        int hold;
        t_sector_cmd got;
        wait (rst_n === 1'b1);
        forever begin
            hold = draw_wait();
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            got.addr     = sector_addr;
            got.index    = sector_index;
            got.is_write = is_write;
            got.slot     = slot_used;
            got.status   = t_status'(status);
            got.last     = last;
            alloc_sb.check_result(got);
        end
    end

    // Stimulus
    initial begin : stimulus
        logic [CFG_W-1:0] phase_count[9];
        int               phase_items[9];
        int               phase_alloc[9];
        alloc_sb = new();
        phase_count = '{11'd1024, 11'd40, 11'd1, 11'd2047, 11'd9, 11'd0, 11'd1023,
                        CFG_W'($urandom_range(0, 2047)), 11'd1024};
        phase_items = '{110, 50, 15, 60, 30, 10, 40, 35, 40};
        phase_alloc = '{80, 50, 50, 70, 50, 50, 40, 60, 50};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset count: frees of empty slots, first-fit reuse, double free
        issue_request(REQ_SWAP_IN, 10'd0);
        issue_request(REQ_SWAP_IN, 10'd1023);
        issue_request(REQ_SWAP_OUT, 10'd1023);
        issue_request(REQ_SWAP_OUT, 10'd0);
        issue_request(REQ_SWAP_OUT, 10'd512);
        issue_request(REQ_SWAP_IN, 10'd1);
        issue_request(REQ_SWAP_OUT, 10'd341);
        issue_request(REQ_SWAP_IN, 10'd2);
        issue_request(REQ_SWAP_IN, 10'd2);
        wait_for_results();

        // Zero count: full on every allocation, range error on every free
        write_slot_count(11'd0);
        issue_request(REQ_SWAP_OUT, 10'd0);
        issue_request(REQ_SWAP_IN, 10'd0);

        // Oversized count behaves as the whole array
        write_slot_count(11'd2047);
        issue_request(REQ_SWAP_IN, 10'd1023);
        issue_request(REQ_SWAP_IN, 10'd0);

        // Tiny count: fill it, then hit the limit
        write_slot_count(11'd2);
        issue_request(REQ_SWAP_OUT, 10'd682);
        issue_request(REQ_SWAP_OUT, 10'd0);
        issue_request(REQ_SWAP_IN, 10'd2);
        issue_request(REQ_SWAP_IN, 10'd1);
        write_slot_count(11'd1024);
        issue_request(REQ_SWAP_OUT, 10'd0);
        issue_request(REQ_SWAP_OUT, 10'd1023);

        // Shrunk count: slots above it stay occupied until it grows again
        write_slot_count(11'd1);
        issue_request(REQ_SWAP_IN, 10'd1);
        issue_request(REQ_SWAP_OUT, 10'd0);
        write_slot_count(11'd1024);
        issue_request(REQ_SWAP_IN, 10'd1);

        // Random phases over several slot counts
        for (int p = 0; p < 9; p++) begin
            write_slot_count(phase_count[p]);
            for (int n = 0; n < phase_items[p]; n++) begin
                if ($urandom_range(0, 29) == 0) burst_mode = !burst_mode;
                random_request(phase_alloc[p]);
            end
        end

        wait_for_results();
        repeat (16) @(posedge clk);
        alloc_sb.check_drained();
        $display("Covered %0d requests, %0d results, %0d slot count settings, deepest slot %0d.",
                 alloc_sb.requests, alloc_sb.results, settings_used, alloc_sb.deepest_slot);
        $display("Status counts: ok %0d, full %0d, not occupied %0d, out of range %0d.",
                 alloc_sb.status_seen[ST_OK], alloc_sb.status_seen[ST_FULL],
                 alloc_sb.status_seen[ST_NOT_OCC], alloc_sb.status_seen[ST_RANGE]);
        if (alloc_sb.mismatches == 0)
            $display("swap_slot_bitmap_allocator_unit: match");
        else
            $display("swap_slot_bitmap_allocator_unit: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
src/ssba_pkg.sv
src/ssba_ram.sv
src/ssba_ctrl.sv
src/ssba_dp.sv
src/swap_slot_bitmap_allocator_unit.sv
dv/tb.sv
